>>> design/priority_voice_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Priority voice allocator - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_VOICE_ALLOCATOR_CORE_ASSERT_SVH
`define PRIORITY_VOICE_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define PVA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PVA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error(msg);

`endif

>>> design/pva_pkg.sv
// ----------------------------------------------------------------------------
// Priority voice allocator - package
// Field widths, status codes and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package pva_pkg;

	localparam int ID_W    = 6;
	localparam int PRIO_W  = 8;
	localparam int PITCH_W = 16;
	localparam int MASK_W  = 8;
	localparam int CFG_W   = 7;
	localparam int VIDX_W  = 3;
	localparam int STAT_W  = 2;

	// Largest sound table the block addresses; ids at or above are rejected.
	localparam logic [8:0] SOUNDS_LIMIT = 9'd64;

	localparam logic [PRIO_W-1:0] PRIORITY_MAX = 8'hFF;

	typedef enum logic [STAT_W-1:0] {
		ST_STARTED  = 2'd0,
		ST_BAD_ID   = 2'd1,
		ST_NO_VOICE = 2'd2
	} pva_status_t;

	typedef struct packed {
		logic capture;
		logic scan;
		logic reject;
		logic decide;
		logic load;
	} pva_cmd_t;

	typedef struct packed {
		logic id_ok;
		logic scan_last;
		logic out_free;
	} pva_sts_t;

endpackage

>>> design/pva_if.sv
// ----------------------------------------------------------------------------
// Priority voice allocator - channel interfaces
// Valid/ready request and result channels with their payload fields.
// ----------------------------------------------------------------------------
interface pva_req_if;
	logic                          valid;
	logic                          ready;
	logic [pva_pkg::ID_W-1:0]      sound_id;
	logic [pva_pkg::PRIO_W-1:0]    request_priority;
	logic [pva_pkg::PITCH_W-1:0]   pitch_q8_8;
	logic [pva_pkg::MASK_W-1:0]    playing_mask;

	modport source (output valid, sound_id, request_priority, pitch_q8_8, playing_mask,
		input ready);
	modport sink (input valid, sound_id, request_priority, pitch_q8_8, playing_mask,
		output ready);
endinterface

interface pva_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [pva_pkg::STAT_W-1:0]    status;
	logic [pva_pkg::VIDX_W-1:0]    voice_index;
	logic                          stolen;
	logic [pva_pkg::ID_W-1:0]      sound_out;
	logic [pva_pkg::PITCH_W-1:0]   pitch_out;

	modport source (output valid, status, voice_index, stolen, sound_out, pitch_out,
		input ready);
	modport sink (input valid, status, voice_index, stolen, sound_out, pitch_out,
		output ready);
endinterface

>>> design/pva_ctrl.sv
// ----------------------------------------------------------------------------
// Priority voice allocator - controller
// Sequences capture, id check, voice scan, grant and result load.
// ----------------------------------------------------------------------------
`include "priority_voice_allocator_core_assert.svh"

module pva_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  pva_pkg::pva_sts_t sts,
	output pva_pkg::pva_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_CHECK  = 5'b00010,
		S_SCAN   = 5'b00100,
		S_DECIDE = 5'b01000,
		S_RESULT = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.id_ok) begin
					state_d = S_SCAN;
				end else begin
					cmd.reject = 1'b1;
					state_d    = S_RESULT;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = S_RESULT;
			end
			S_RESULT: begin
				// hold until the output slot frees up
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`PVA_ASSERT_NEXT(a_result_held, (state_q == S_RESULT) && !sts.out_free,
		state_q == S_RESULT, "result dropped while output slot busy")
	`PVA_ASSERT_NEXT(a_scan_ends_in_decide, (state_q == S_SCAN) && sts.scan_last,
		state_q == S_DECIDE, "scan did not hand over to grant")

endmodule

>>> design/pva_datapath.sv
// ----------------------------------------------------------------------------
// Priority voice allocator - datapath
// Voice table, one-voice-per-cycle reclaim/search scan and result register.
// ----------------------------------------------------------------------------
`include "priority_voice_allocator_core_assert.svh"

module pva_datapath #(
	parameter int VOICES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pva_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic [pva_pkg::ID_W-1:0]      sound_id,
	input  logic [pva_pkg::PRIO_W-1:0]    request_priority,
	input  logic [pva_pkg::PITCH_W-1:0]   pitch_q8_8,
	input  logic [pva_pkg::MASK_W-1:0]    playing_mask,
	input  pva_pkg::pva_cmd_t             cmd,
	output pva_pkg::pva_sts_t             sts,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [pva_pkg::STAT_W-1:0]    status,
	output logic [pva_pkg::VIDX_W-1:0]    voice_index,
	output logic                          stolen,
	output logic [pva_pkg::ID_W-1:0]      sound_out,
	output logic [pva_pkg::PITCH_W-1:0]   pitch_out
);

	localparam int CW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam logic [CW-1:0] LAST_VOICE = CW'(VOICES - 1);

	// configuration
	logic [pva_pkg::CFG_W-1:0]   reg_sounds_q;

	// captured request
	logic [pva_pkg::ID_W-1:0]    req_id_q;
	logic [pva_pkg::PRIO_W-1:0]  req_prio_q;
	logic [pva_pkg::PITCH_W-1:0] req_pitch_q;
	logic [pva_pkg::MASK_W-1:0]  req_mask_q;

	// voice table
	logic                        active_q [VOICES];
	logic [pva_pkg::PRIO_W-1:0]  prio_q   [VOICES];

	// scan state
	logic [CW-1:0]               cnt_q;
	logic                        found_q;
	logic [CW-1:0]               chosen_q;
	logic [CW-1:0]               worst_q;
	logic [pva_pkg::PRIO_W-1:0]  worst_prio_q;

	// result register
	logic                        rsp_valid_q;
	pva_pkg::pva_status_t        res_status_q;
	logic [CW-1:0]               res_voice_q;
	logic                        res_stolen_q;
	pva_pkg::pva_status_t        out_status_q;
	logic [pva_pkg::VIDX_W-1:0]  out_voice_q;
	logic                        out_stolen_q;
	logic [pva_pkg::ID_W-1:0]    out_sound_q;
	logic [pva_pkg::PITCH_W-1:0] out_pitch_q;

	logic [31:0]                 mask_ext;
	logic                        playing;
	logic                        cur_active;
	logic [pva_pkg::PRIO_W-1:0]  cur_prio;
	logic                        reclaim;
	logic                        is_free;
	logic [pva_pkg::PRIO_W-1:0]  eff_prio;
	logic                        grant;
	logic [CW-1:0]               grant_voice;

	// voices past the mask width count as not playing
	assign mask_ext   = {24'd0, req_mask_q};
	assign playing    = mask_ext[5'(cnt_q)];
	assign cur_active = active_q[cnt_q];
	assign cur_prio   = prio_q[cnt_q];
	assign reclaim    = cur_active && !playing;
	assign is_free    = !cur_active || reclaim;
	assign eff_prio   = reclaim ? pva_pkg::PRIORITY_MAX : cur_prio;

	assign grant       = found_q || (worst_prio_q > req_prio_q);
	assign grant_voice = found_q ? chosen_q : worst_q;

	assign sts.id_ok     = ({1'b0, req_id_q} < reg_sounds_q) &&
		({3'd0, req_id_q} < pva_pkg::SOUNDS_LIMIT);
	assign sts.scan_last = (cnt_q == LAST_VOICE);
	assign sts.out_free  = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_sounds_q <= '0;
		end else if (cfg_we) begin
			reg_sounds_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_id_q    <= sound_id;
			req_prio_q  <= request_priority;
			req_pitch_q <= pitch_q8_8;
			req_mask_q  <= playing_mask;
		end
	end

	// voice table: reclaim during the scan, grant afterwards
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICES; i++) begin
				active_q[i] <= 1'b0;
				prio_q[i]   <= pva_pkg::PRIORITY_MAX;
			end
		end else if (cmd.scan && reclaim) begin
			active_q[cnt_q] <= 1'b0;
			prio_q[cnt_q]   <= pva_pkg::PRIORITY_MAX;
		end else if (cmd.decide && grant) begin
			active_q[grant_voice] <= 1'b1;
			prio_q[grant_voice]   <= req_prio_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.capture) begin
			cnt_q   <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan) begin
			if (!sts.scan_last) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (is_free && !found_q) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			if (is_free && !found_q) begin
				chosen_q <= cnt_q;
			end
			// strict compare keeps the first voice on ties
			if ((cnt_q == '0) || (eff_prio > worst_prio_q)) begin
				worst_q      <= cnt_q;
				worst_prio_q <= eff_prio;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.reject) begin
			res_status_q <= pva_pkg::ST_BAD_ID;
			res_voice_q  <= '0;
			res_stolen_q <= 1'b0;
		end else if (cmd.decide) begin
			res_status_q <= grant ? pva_pkg::ST_STARTED : pva_pkg::ST_NO_VOICE;
			res_voice_q  <= grant ? grant_voice : '0;
			res_stolen_q <= grant && !found_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_status_q <= res_status_q;
			out_voice_q  <= pva_pkg::VIDX_W'(res_voice_q);
			out_stolen_q <= res_stolen_q;
			out_sound_q  <= req_id_q;
			out_pitch_q  <= req_pitch_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = out_status_q;
	assign voice_index = out_voice_q;
	assign stolen      = out_stolen_q;
	assign sound_out   = out_sound_q;
	assign pitch_out   = out_pitch_q;

	`PVA_ASSERT_NOW(a_load_into_free_slot, cmd.load, sts.out_free,
		"result loaded over an unread result")
	`PVA_ASSERT_NEXT(a_free_voice_not_stolen, cmd.decide && found_q, !res_stolen_q,
		"voice stolen although a free voice was found")
	`PVA_ASSERT_NOW(a_stolen_only_started, rsp_valid_q && out_stolen_q,
		out_status_q == pva_pkg::ST_STARTED, "stolen flag on a rejected request")
	`PVA_ASSERT_NOW(a_scan_in_range, cmd.scan, cnt_q <= LAST_VOICE,
		"scan counter past last voice")

endmodule

>>> design/priority_voice_allocator_core.sv
// ----------------------------------------------------------------------------
// Priority voice allocator - top level
// Assigns play requests to mixer voices, reclaiming finished voices and
// stealing the least important voice when none is free, if it ranks below the request.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+-----------------------------------------------------
//   req     | in  | valid / ready | sound_id, request_priority, pitch_q8_8, playing_mask
//   rsp     | out | valid / ready | status, voice_index, stolen, sound_out, pitch_out
//   cfg     | in  | cfg_we        | cfg_wdata = registered_sounds
//
// One item at a time: a valid request goes from accept to result through check, the table
// scan (one voice per cycle), grant and load; a rejected id goes through check and load.
// The result waits in an output register while the next item is accepted; a stalled
// rsp holds the following result in its final state. Reset clears all voices to
// inactive at priority max and the sound count to zero; no clearing pass follows.
// ----------------------------------------------------------------------------
module priority_voice_allocator_core #(
	parameter int VOICES = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [pva_pkg::CFG_W-1:0] cfg_wdata,
	pva_req_if.sink                   req,
	pva_rsp_if.source                 rsp
);

	// command and status between sequencer and datapath
	pva_pkg::pva_cmd_t cmd;
	pva_pkg::pva_sts_t sts;

	// sequencer: owns the request handshake and the step order
	pva_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: voice table, scan registers and the result register
	pva_datapath #(
		.VOICES (VOICES)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.sound_id         (req.sound_id),
		.request_priority (req.request_priority),
		.pitch_q8_8       (req.pitch_q8_8),
		.playing_mask     (req.playing_mask),
		.cmd              (cmd),
		.sts              (sts),
		.rsp_valid        (rsp.valid),
		.rsp_ready        (rsp.ready),
		.status           (rsp.status),
		.voice_index      (rsp.voice_index),
		.stolen           (rsp.stolen),
		.sound_out        (rsp.sound_out),
		.pitch_out        (rsp.pitch_out)
	);

endmodule
